>>> hdl/vnorm_pkg.sv
// vnorm_pkg: shared types for the 3-D vector normalizer.
// Used by vnorm_front, vnorm_cell and vector3_normalizer_top; no dependencies.
`default_nettype none
package vnorm_pkg;

    typedef struct packed {
        logic       vld;
        logic       zero;
        logic [2:0] neg;
    } vn_ctrl_t;

endpackage
`default_nettype wire

>>> hdl/vnorm_front.sv
// vnorm_front: magnitudes, squares, sum of squares and scaled numerators.
// Three register stages; depends on vnorm_pkg.
`default_nettype none
module vnorm_front #(
    parameter int W  = 16,
    parameter int F  = 14,
    parameter int PW = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_vld,
    input  wire logic [2:0][W-1:0]     in_comp,
    output vnorm_pkg::vn_ctrl_t        ctrl_out,
    output logic [2*W-1:0]             sum_out,
    output logic [2:0][PW-1:0]         num_out
);
    import vnorm_pkg::*;

    vn_ctrl_t              a_ctrl_reg, b_ctrl_reg, c_ctrl_reg;
    logic [2:0][W-1:0]     mag_reg;
    logic [2:0][2*W-1:0]   sq_reg;
    logic [2*W-1:0]        sum_reg;
    logic [2:0][PW-1:0]    num_reg;
    logic [2*W-1:0]        sum_next;

    assign sum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_ctrl_reg <= '0;
            b_ctrl_reg <= '0;
            c_ctrl_reg <= '0;
        end else if (en) begin
            a_ctrl_reg.vld  <= in_vld;
            a_ctrl_reg.zero <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                a_ctrl_reg.neg[i] <= in_comp[i][W-1];
            end
            b_ctrl_reg <= a_ctrl_reg;
            c_ctrl_reg <= '{vld: b_ctrl_reg.vld, zero: (sum_next == '0),
                            neg: b_ctrl_reg.neg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                mag_reg[i] <= in_comp[i][W-1] ? (~in_comp[i] + 1'b1) : in_comp[i];
                sq_reg[i]  <= mag_reg[i] * mag_reg[i];
                num_reg[i] <= PW'(sq_reg[i]) << (2 * F);
            end
            sum_reg <= sum_next;
        end
    end

    assign ctrl_out = c_ctrl_reg;
    assign sum_out  = sum_reg;
    assign num_out  = num_reg;

endmodule
`default_nettype wire

>>> hdl/vnorm_cell.sv
// vnorm_cell: decides one quotient bit of all three components.
// Keeps q*q*S and q*S incrementally, so only shifts, adds and compares. Uses vnorm_pkg.
`default_nettype none
module vnorm_cell #(
    parameter int W   = 16,
    parameter int F   = 14,
    parameter int PW  = 64,
    parameter int BIT = 0
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire vnorm_pkg::vn_ctrl_t   ctrl_in,
    input  wire logic [2*W-1:0]        sum_in,
    input  wire logic [2:0][PW-1:0]    num_in,
    input  wire logic [2:0][PW-1:0]    p_in,
    input  wire logic [2:0][PW-1:0]    r_in,
    input  wire logic [2:0][F:0]       q_in,
    output vnorm_pkg::vn_ctrl_t        ctrl_out,
    output logic [2*W-1:0]             sum_out,
    output logic [2:0][PW-1:0]         num_out,
    output logic [2:0][PW-1:0]         p_out,
    output logic [2:0][PW-1:0]         r_out,
    output logic [2:0][F:0]            q_out
);
    import vnorm_pkg::*;

    vn_ctrl_t             ctrl_reg;
    logic [2*W-1:0]       sum_reg;
    logic [2:0][PW-1:0]   num_reg, p_reg, r_reg;
    logic [2:0][F:0]      q_reg;
    logic [2:0][PW-1:0]   cand_p;
    logic [2:0]           take;

    // (q + 2^b)^2 S = qqS + 2^(b+1) qS + 2^(2b) S
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cand_p[i] = p_in[i] + (r_in[i] << (BIT + 1)) + (PW'(sum_in) << (2 * BIT));
            take[i]   = (cand_p[i] <= num_in[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_in;
            num_reg <= num_in;
            for (int i = 0; i < 3; i++) begin
                if (take[i]) begin
                    p_reg[i] <= cand_p[i];
                    r_reg[i] <= r_in[i] + (PW'(sum_in) << BIT);
                    q_reg[i] <= q_in[i] | ((F+1)'(1) << BIT);
                end else begin
                    p_reg[i] <= p_in[i];
                    r_reg[i] <= r_in[i];
                    q_reg[i] <= q_in[i];
                end
            end
        end
    end

    assign ctrl_out = ctrl_reg;
    assign sum_out  = sum_reg;
    assign num_out  = num_reg;
    assign p_out    = p_reg;
    assign r_out    = r_reg;
    assign q_out    = q_reg;

endmodule
`default_nettype wire

>>> hdl/vector3_normalizer_top.sv
// vector3_normalizer_top: normalizes a signed 3-vector to unit length in Q1.F.
// Instantiates vnorm_front and a chain of vnorm_cell; uses vnorm_pkg.
//
// Usage:
//   Slave channel s_*: one word per vector, x/y/z components packed in s_tdata.
//   Master channel m_*: one word per vector, unit_x/y/z packed in m_tdata.
//   Each result is sign(c) * floor(|c| * 2^F / |v|); a zero vector gives zeros.
// Pipeline: three front stages (magnitude, square, sum), one cell per quotient bit,
//   one output register.
// Throughput: one word per cycle unless stalled; the whole pipeline moves on a single enable.
// Stall: while m_tvalid is high and m_tready low, the pipeline freezes and
//   s_tready drops; the held word stays stable until taken.
// Reset: aresetn low clears all valid bits; no word is in flight afterwards.
`default_nettype none
module vector3_normalizer_top #(
    parameter int IN_WIDTH  = 16,
    parameter int FRAC_BITS = 14
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     s_tvalid,
    output logic                                          s_tready,
    // comp_x, comp_y, comp_z (IN_WIDTH each), zero padded to bytes
    input  wire logic [((3*IN_WIDTH+7)/8)*8-1:0]          s_tdata,
    output logic                                          m_tvalid,
    input  wire logic                                     m_tready,
    // unit_x, unit_y, unit_z (FRAC_BITS+2 each), zero padded to bytes
    output logic [((3*(FRAC_BITS+2)+7)/8)*8-1:0]          m_tdata
);
    import vnorm_pkg::*;

    localparam int W      = IN_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int OW     = F + 2;
    localparam int PW     = 2 * F + 2 * W + 4;
    localparam int NCELL  = F + 1;
    localparam int ODW    = ((3 * OW + 7) / 8) * 8;

    logic                         en;
    logic [2:0][W-1:0]            comp;
    vn_ctrl_t                     ctrl   [NCELL+1];
    logic [2*W-1:0]               sum_w  [NCELL+1];
    logic [2:0][PW-1:0]           num_w  [NCELL+1];
    logic [2:0][PW-1:0]           p_w    [NCELL+1];
    logic [2:0][PW-1:0]           r_w    [NCELL+1];
    logic [2:0][F:0]              q_w    [NCELL+1];
    logic                         m_tvalid_reg;
    logic [2:0][OW-1:0]           unit_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            comp[i] = s_tdata[i*W +: W];
        end
    end

    vnorm_front #(.W(W), .F(F), .PW(PW)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s_tvalid),
        .in_comp  (comp),
        .ctrl_out (ctrl[0]),
        .sum_out  (sum_w[0]),
        .num_out  (num_w[0])
    );

    assign p_w[0] = '0;
    assign r_w[0] = '0;
    assign q_w[0] = '0;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        vnorm_cell #(.W(W), .F(F), .PW(PW), .BIT(F - k)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .ctrl_in  (ctrl[k]),
            .sum_in   (sum_w[k]),
            .num_in   (num_w[k]),
            .p_in     (p_w[k]),
            .r_in     (r_w[k]),
            .q_in     (q_w[k]),
            .ctrl_out (ctrl[k+1]),
            .sum_out  (sum_w[k+1]),
            .num_out  (num_w[k+1]),
            .p_out    (p_w[k+1]),
            .r_out    (r_w[k+1]),
            .q_out    (q_w[k+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= ctrl[NCELL].vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (ctrl[NCELL].zero) begin
                    unit_reg[i] <= '0;
                end else if (ctrl[NCELL].neg[i]) begin
                    unit_reg[i] <= ~{1'b0, q_w[NCELL][i]} + 1'b1;
                end else begin
                    unit_reg[i] <= {1'b0, q_w[NCELL][i]};
                end
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = ODW'(unit_reg);

endmodule
`default_nettype wire

>>> hdl/vnorm_checker.sv
// vnorm_checker: port-level assertions for vector3_normalizer_top, with its bind.
// Sees only the top-level ports; no package dependency.
`default_nettype none
module vnorm_checker #(
    parameter int IN_WIDTH  = 16,
    parameter int FRAC_BITS = 14
) (
    input wire logic                                  aclk,
    input wire logic                                  aresetn,
    input wire logic                                  s_tready,
    input wire logic                                  m_tvalid,
    input wire logic                                  m_tready,
    input wire logic [((3*(FRAC_BITS+2)+7)/8)*8-1:0]  m_tdata
);
    localparam int OW = FRAC_BITS + 2;

    logic signed [OW-1:0] ux, uy, uz;
    assign ux = m_tdata[OW-1:0];
    assign uy = m_tdata[2*OW-1:OW];
    assign uz = m_tdata[3*OW-1:2*OW];

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled word changed");

    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready not tied to output space");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (ux <= (1 << FRAC_BITS)) && (ux >= -(1 << FRAC_BITS))
                  && (uy <= (1 << FRAC_BITS)) && (uy >= -(1 << FRAC_BITS))
                  && (uz <= (1 << FRAC_BITS)) && (uz >= -(1 << FRAC_BITS)))
        else $error("unit component out of range");

endmodule

bind vector3_normalizer_top vnorm_checker #(
    .IN_WIDTH  (IN_WIDTH),
    .FRAC_BITS (FRAC_BITS)
) u_vnorm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

>>> tb/tb.sv
// tb: self-checking testbench for vector3_normalizer_top (IN_WIDTH 16, FRAC_BITS 14).
// Drives random and corner vectors, predicts unit vectors by exact integer square root.
// Depends only on vector3_normalizer_top.
`timescale 1ns / 1ps
module tb;

    localparam int IW = 16;
    localparam int FB = 14;
    localparam int OW = FB + 2;
    localparam int LAT = FB + 5;

    typedef struct packed {
        logic signed [IW-1:0] z;
        logic signed [IW-1:0] y;
        logic signed [IW-1:0] x;
    } vec_t;

    typedef struct packed {
        logic signed [OW-1:0] z;
        logic signed [OW-1:0] y;
        logic signed [OW-1:0] x;
    } unit_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [47:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [47:0] m_tdata;

    vec_t  vec_queue[$];
    unit_t unit_expected[$];
    int    errors = 0;
    bit    stim_done = 0;
    bit    src_idle_free = 0;
    bit    sink_idle_free = 0;
    bit    sender_pause = 0;
    int    hold_cycles = 0;

    always #2 aclk = ~aclk;

    vector3_normalizer_top #(.IN_WIDTH(IW), .FRAC_BITS(FB)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // largest q with q*q*sum <= c*c*2^(2*FB), sign applied
    function automatic logic signed [OW-1:0] unit_comp(logic signed [IW-1:0] c,
                                                       logic [63:0] sum);
        logic [31:0]  mag;
        logic [127:0] num;
        logic [127:0] prod;
        logic [31:0]  q;
        logic [31:0]  cand;
        mag = (c < 0) ? -32'(c) : 32'(c);
        if (sum == 0 || mag == 0) return '0;
        num = 128'(mag) * 128'(mag) << (2 * FB);
        q = 0;
        for (int b = FB; b >= 0; b--) begin
            cand = q | (32'd1 << b);
            prod = 128'(cand) * 128'(cand) * 128'(sum);
            if (prod <= num) q = cand;
        end
        return (c < 0) ? -OW'(q) : OW'(q);
    endfunction

    function automatic unit_t normalize(vec_t v);
        logic [63:0] sum;
        unit_t u;
        sum = 64'(32'(v.x) * 32'(v.x)) + 64'(32'(v.y) * 32'(v.y))
            + 64'(32'(v.z) * 32'(v.z));
        sum = 64'(longint'(v.x) * v.x) + 64'(longint'(v.y) * v.y)
            + 64'(longint'(v.z) * v.z);
        u.x = unit_comp(v.x, sum);
        u.y = unit_comp(v.y, sum);
        u.z = unit_comp(v.z, sum);
        return u;
    endfunction

    function automatic logic signed [IW-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return IW'($urandom_range(0, 15)) - 16'sd8;
            1: return 16'sh8000 + IW'($urandom_range(0, 3));
            2: return 16'sh7fff - IW'($urandom_range(0, 3));
            3: return IW'($urandom_range(0, 511)) - 16'sd256;
            default: return IW'($urandom);
        endcase
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (vec_queue.size() > 0 && !sender_pause
                && (src_idle_free || $urandom_range(0, 99) >= 29)) begin
                s_tvalid <= 1'b1;
                s_tdata <= vec_queue.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // expectation on acceptance
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            unit_expected.push_back(normalize(vec_t'(s_tdata)));
    end

    // sink ready with idling and one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= sink_idle_free || ($urandom_range(0, 99) >= 29);
        end
    end

    // monitor
    always @(posedge aclk) begin
        unit_t got;
        unit_t exp_u;
        if (aresetn && m_tvalid && m_tready) begin
            got = unit_t'(m_tdata);
            if (unit_expected.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %h", got);
            end else begin
                exp_u = unit_expected.pop_front();
                if (got !== exp_u) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                                 exp_u.x, exp_u.y, exp_u.z, got.x, got.y, got.z);
                end
            end
        end
    end

    task automatic wait_drain();
        while (vec_queue.size() > 0 || s_tvalid || unit_expected.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        vec_t v;
        logic signed [IW-1:0] ext[4];
        ext = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: zero, axes, extremes, equal comps
        vec_queue.push_back('{0, 0, 0});
        vec_queue.push_back('{z: 0, y: 0, x: 1});
        vec_queue.push_back('{z: 0, y: -16'sd1, x: 0});
        vec_queue.push_back('{z: 16'sh8000, y: 0, x: 0});
        vec_queue.push_back('{z: 0, y: 0, x: 16'sh7fff});
        vec_queue.push_back('{z: 16'sh8000, y: 16'sh8000, x: 16'sh8000});
        vec_queue.push_back('{z: 16'sh7fff, y: 16'sh7fff, x: 16'sh7fff});
        vec_queue.push_back('{z: 16'sh8000, y: 16'sh7fff, x: 16'sh8000});
        vec_queue.push_back('{z: 1, y: 1, x: 1});
        vec_queue.push_back('{z: 0, y: 4, x: 3});
        vec_queue.push_back('{z: -16'sd2, y: 0, x: -16'sd2});
        vec_queue.push_back('{z: 16'sh8000, y: 0, x: 1});
        for (int i = 0; i < 12; i++) begin
            v.x = ext[$urandom_range(0, 3)];
            v.y = ext[$urandom_range(0, 3)];
            v.z = ext[$urandom_range(0, 3)];
            vec_queue.push_back(v);
        end
        // random, with a long idle-free stretch
        for (int i = 0; i < 1650; i++) begin
            v.x = rand_comp(); v.y = rand_comp(); v.z = rand_comp();
            vec_queue.push_back(v);
        end
        while (vec_queue.size() > 1300) @(posedge aclk);
        hold_cycles <= 200;
        while (vec_queue.size() > 1000) @(posedge aclk);
        sender_pause <= 1'b1;
        while (s_tvalid || unit_expected.size() > 0) @(posedge aclk);
        sender_pause <= 1'b0;
        src_idle_free <= 1'b1;
        sink_idle_free <= 1'b1;
        while (vec_queue.size() > 700) @(posedge aclk);
        src_idle_free <= 1'b0;
        sink_idle_free <= 1'b0;
        wait_drain();
        repeat (LAT + 10) @(posedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #200000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
